/* sv/rfdt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ring fault diagnosis table: shared package
// Event kinds, belief codes, bus widths, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rfdt_pkg;

  // Default ring capacity
  localparam int MAX_PROCESSES_DEF = 8;

  // Bus widths
  localparam int S_TDATA_W = 8;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;
  localparam int CFG_W     = 4;
  localparam logic [CFG_W-1:0] PROCESS_COUNT_RST = 4'd8;

  // Event kinds
  localparam logic [1:0] KIND_TEST    = 2'd0;
  localparam logic [1:0] KIND_FAULT   = 2'd1;
  localparam logic [1:0] KIND_RECOVER = 2'd2;

  // Belief codes
  localparam logic [1:0] BELIEF_UNKNOWN = 2'd0;
  localparam logic [1:0] BELIEF_CORRECT = 2'd1;
  localparam logic [1:0] BELIEF_FAULTY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_TESTER,
    ST_LOAD_TESTER,
    ST_WALK,
    ST_LOAD_TARGET,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic rd_tester;
    logic load_tester;
    logic walk_step;
    logic rd_target;
    logic merge;
    logic wr;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic walk_ok;
    logic p_is_tester;
    logic p_faulty;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* sv/ring_fault_diagnosis_table.sv */
`default_nettype none
// Every event reads the tester row; a fault, recovery, skipped test or
// process outside the ring then goes straight to the result. A test walks
// until a correct process, whose row is merged, or the tester, then writes back.
// Events are handled one at a time; the next request is taken once the result
// is loaded, so a new event is not accepted before the last one is through.
// Reset (rst, synchronous): fault flags cleared, all table rows read as reset.
// ----------------------------------------------------------------------------
// Ring fault diagnosis table
// Adaptive self-diagnosis on a ring: fault flags, belief table, ring walk
// and belief merge, with stream input and output channels.
// ----------------------------------------------------------------------------
module ring_fault_diagnosis_table
  import rfdt_pkg::*;
#(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire  [CFG_W-1:0]     cfg_wdata,      // process_count
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire  [S_TDATA_W-1:0] s_tdata,        // [2:0] process, [7:3] zero
  input  wire  [S_TUSER_W-1:0] s_tuser,        // [1:0] kind
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [M_TDATA_W-1:0] m_tdata         // [2:0] tester, [3] skipped,
                                               // [11:4] suspect_mask,
                                               // [12] correct_found,
                                               // [15:13] correct_target,
                                               // [23:16] learned_mask,
                                               // [39:24] belief_row
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  rfdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and walk logic
  rfdt_dp #(
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

/* sv/rfdt_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rfdt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/rfdt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ring fault diagnosis table: controller
// Sequences one event at a time: tester row read, ring walk, target row
// read and merge, write-back and result hand-over.
// ----------------------------------------------------------------------------
module rfdt_ctrl
  import rfdt_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_RD_TESTER;
      end
      ST_RD_TESTER:   state_next = ST_LOAD_TESTER;
      ST_LOAD_TESTER: state_next = sts.walk_ok ? ST_WALK : ST_FINISH;
      ST_WALK: begin
        if (sts.p_is_tester) begin
          state_next = ST_WRITE;
        end else if (!sts.p_faulty) begin
          state_next = ST_LOAD_TARGET;
        end
      end
      ST_LOAD_TARGET: state_next = ST_WRITE;
      ST_WRITE:       state_next = ST_FINISH;
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default:        state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_RD_TESTER:   cmd.rd_tester = 1'b1;
      ST_LOAD_TESTER: cmd.load_tester = 1'b1;
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.rd_target = !sts.p_is_tester && !sts.p_faulty;
      end
      ST_LOAD_TARGET: cmd.merge = 1'b1;
      ST_WRITE:       cmd.wr = 1'b1;
      ST_FINISH:      cmd.out_load = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/rfdt_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Ring fault diagnosis table: datapath
// Fault flags, belief table RAM with per-row valid bits, working row,
// ring pointer, walk masks and the result register.
// ----------------------------------------------------------------------------
module rfdt_dp
  import rfdt_pkg::*;
#(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire  [CFG_W-1:0]      cfg_wdata,
  input  wire  [S_TDATA_W-1:0]  s_tdata,
  input  wire  [S_TUSER_W-1:0]  s_tuser,
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic                  m_tvalid,
  input  wire                   m_tready,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  localparam int IDX_W = $clog2(MAX_PROCESSES);
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam int ROW_W = 2 * MAX_PROCESSES;

  typedef logic [MAX_PROCESSES-1:0][1:0] row_t;

  logic [CFG_W-1:0]         process_count;
  logic [MAX_PROCESSES-1:0] fault_flags;
  logic [MAX_PROCESSES-1:0] row_valid;
  logic [1:0]               kind;
  logic [2:0]               tester;
  logic [IDX_W-1:0]         ptr;
  logic [IDX_W-1:0]         target;
  logic [IDX_W-1:0]         rd_idx;
  logic [MAX_PROCESSES-1:0] tested;
  logic [MAX_PROCESSES-1:0] suspects;
  logic [MAX_PROCESSES-1:0] learned;
  logic                     found;
  row_t                     work;

  logic [CNT_W-1:0] ring_n;
  logic             in_ring;
  logic [IDX_W-1:0] t_idx;
  logic [IDX_W-1:0] next_of_t;
  logic [IDX_W-1:0] next_of_p;
  logic [CNT_W-1:0] t_inc;
  logic [CNT_W-1:0] p_inc;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic [ROW_W-1:0] ram_rdata;
  row_t             rd_row;
  row_t             reset_row;
  row_t             merged_row;
  logic [MAX_PROCESSES-1:0] merged_learned;
  logic [7:0]       suspect_mask;
  logic [7:0]       learned_mask;
  logic [15:0]      belief_row;
  logic [M_TDATA_W-1:0] m_tdata_next;

  // Ring size, clamped to the supported range
  always_comb begin
    if (process_count < 4'd2) begin
      ring_n = CNT_W'(2);
    end else if (32'(process_count) > MAX_PROCESSES) begin
      ring_n = CNT_W'(MAX_PROCESSES);
    end else begin
      ring_n = CNT_W'(process_count);
    end
  end

  assign in_ring = 32'(tester) < 32'(ring_n);
  assign t_idx   = IDX_W'(tester);

  // Successors on the ring
  assign t_inc     = CNT_W'(t_idx) + CNT_W'(1);
  assign p_inc     = CNT_W'(ptr) + CNT_W'(1);
  assign next_of_t = (t_inc == ring_n) ? '0 : IDX_W'(t_inc);
  assign next_of_p = (p_inc == ring_n) ? '0 : IDX_W'(p_inc);

  // Status towards the controller
  assign sts.walk_ok     = in_ring && (kind == KIND_TEST) && !fault_flags[t_idx];
  assign sts.p_is_tester = (ptr == t_idx);
  assign sts.p_faulty    = fault_flags[ptr];
  assign sts.out_free    = !m_tvalid || m_tready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      process_count <= PROCESS_COUNT_RST;
    end else if (cfg_we) begin
      process_count <= cfg_wdata;
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind   <= s_tuser;
      tester <= s_tdata[2:0];
    end
  end

  // Fault flags: applied as soon as the event has been latched
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_flags <= '0;
    end else if (cmd.rd_tester && in_ring) begin
      if (kind == KIND_FAULT) begin
        fault_flags[t_idx] <= 1'b1;
      end else if (kind == KIND_RECOVER) begin
        fault_flags[t_idx] <= 1'b0;
      end
    end
  end

  // Belief table: one row per process
  assign re    = cmd.rd_tester || cmd.rd_target;
  assign raddr = cmd.rd_target ? ptr : t_idx;

  rfdt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_PROCESSES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (t_idx),
    .wdata (work),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (re) begin
      rd_idx <= raddr;
    end
  end

  // A row never written reads as its reset value: only its own entry correct
  always_comb begin
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      reset_row[i] = (IDX_W'(i) == rd_idx) ? BELIEF_CORRECT : BELIEF_UNKNOWN;
    end
  end

  assign rd_row = row_valid[rd_idx] ? row_t'(ram_rdata) : reset_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.wr) begin
      row_valid[t_idx] <= 1'b1;
    end
  end

  // Merge of the target's known beliefs about untested processes
  always_comb begin
    merged_row     = work;
    merged_learned = '0;
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      if ((32'(i) < 32'(ring_n)) && !tested[i] && (rd_row[i] != BELIEF_UNKNOWN)) begin
        merged_row[i]     = rd_row[i];
        merged_learned[i] = 1'b1;
      end
    end
  end

  // Working row, ring pointer and walk masks
  always_ff @(posedge clk) begin
    if (cmd.load_tester) begin
      work     <= rd_row;
      tested   <= MAX_PROCESSES'(1) << t_idx;
      suspects <= '0;
      learned  <= '0;
      found    <= 1'b0;
      target   <= '0;
      ptr      <= next_of_t;
    end else if (cmd.walk_step && !sts.p_is_tester) begin
      tested[ptr] <= 1'b1;
      if (sts.p_faulty) begin
        work[ptr]     <= BELIEF_FAULTY;
        suspects[ptr] <= 1'b1;
        ptr           <= next_of_p;
      end else begin
        work[ptr] <= BELIEF_CORRECT;
        found     <= 1'b1;
        target    <= ptr;
      end
    end else if (cmd.merge) begin
      work    <= merged_row;
      learned <= merged_learned;
    end
  end

  // Result fields, limited to the first eight processes of the ring
  always_comb begin
    suspect_mask = '0;
    learned_mask = '0;
    belief_row   = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < MAX_PROCESSES) begin
        suspect_mask[i] = suspects[i % MAX_PROCESSES];
        learned_mask[i] = learned[i % MAX_PROCESSES];
        if (32'(i) < 32'(ring_n)) begin
          belief_row[2*i +: 2] = work[i % MAX_PROCESSES];
        end
      end
    end
  end

  // Result word: walk fields only for a walked test, row only inside the ring
  always_comb begin
    m_tdata_next      = '0;
    m_tdata_next[2:0] = tester;
    m_tdata_next[3]   = !sts.walk_ok;
    if (sts.walk_ok) begin
      m_tdata_next[11:4]  = suspect_mask;
      m_tdata_next[12]    = found;
      m_tdata_next[15:13] = 3'(target);
      m_tdata_next[23:16] = learned_mask;
    end
    if (in_ring) begin
      m_tdata_next[39:24] = belief_row;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= m_tdata_next;
    end
  end

`ifndef SYNTHESIS
  // The tester is always part of its own tested set while walking
  a_tester_tested: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> tested[t_idx])
    else $error("tester missing from tested set");

  // A correct target is never the tester itself
  a_target_not_tester: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && sts.walk_ok && found) |-> (target != t_idx))
    else $error("correct target equals tester");

  // A written-back row is marked valid afterwards
  a_row_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |=> row_valid[t_idx])
    else $error("row not marked valid after write");

  // Skipped results carry empty walk fields
  a_skip_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> (m_tdata[23:4] == 20'd0))
    else $error("skipped result with walk fields set");
`endif

endmodule
`default_nettype wire
